// ===== hw/rtl/ssmf_pkg.sv =====
// Shared types, character codes and helper functions for the SIP stream framer.
`default_nettype none

package ssmf_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // Length of the "\nContent-Length: " search pattern
  localparam logic [4:0] PATTERN_LEN = 5'd17;

  // Message framing phase
  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,  // inside a header line
    PH_NL   = 3'b010,  // just after a newline
    PH_BODY = 3'b100   // counting body bytes
  } phase_t;

  // Content-Length field parse phase
  typedef enum logic [3:0] {
    NP_MATCH = 4'b0001,  // still looking for the field name
    NP_BLANK = 4'b0010,  // skipping spaces and tabs
    NP_DIGIT = 4'b0100,  // accumulating digits
    NP_DONE  = 4'b1000   // value complete
  } nphase_t;

  // ASCII lower-casing
  function automatic logic [7:0] lower_char(input logic [7:0] c);
    lower_char = (c >= CH_UP_A && c <= CH_UP_Z) ? 8'(c + 8'd32) : c;
  endfunction

  // Lower-case search pattern, one character per position
  function automatic logic [7:0] pattern_char(input logic [4:0] pos);
    unique case (pos)
      5'd0:    pattern_char = 8'h0A;  // newline
      5'd1:    pattern_char = 8'h63;  // c
      5'd2:    pattern_char = 8'h6F;  // o
      5'd3:    pattern_char = 8'h6E;  // n
      5'd4:    pattern_char = 8'h74;  // t
      5'd5:    pattern_char = 8'h65;  // e
      5'd6:    pattern_char = 8'h6E;  // n
      5'd7:    pattern_char = 8'h74;  // t
      5'd8:    pattern_char = 8'h2D;  // -
      5'd9:    pattern_char = 8'h6C;  // l
      5'd10:   pattern_char = 8'h65;  // e
      5'd11:   pattern_char = 8'h6E;  // n
      5'd12:   pattern_char = 8'h67;  // g
      5'd13:   pattern_char = 8'h74;  // t
      5'd14:   pattern_char = 8'h68;  // h
      5'd15:   pattern_char = 8'h3A;  // :
      5'd16:   pattern_char = 8'h20;  // space
      default: pattern_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sip_stream_message_framer_unit.sv =====
// SIP stream message framer: marks message ends from blank lines and Content-Length.
//
// Usage:
//  - Input channel (in_*): one request per byte. in_tuser selects a data byte (0)
//    or a parser restart after the connection closed (1); a restart gives no result.
//  - Output channel (out_*): one result per data byte, the byte passed through with
//    tlast set on the last byte of a message, in_body on body bytes, and the
//    Content-Length value parsed so far with its saturation flag.
//  - Results are registered: a byte accepted at an edge shows on out_* after it.
//  - Throughput is one byte per cycle while results are taken; the single result
//    register decides it; in_tready stays high while it is empty or being taken.
//  - When the receiver stalls, the result holds and in_tready drops until it is taken.
//  - Reset (rst_n low, synchronous) empties the result register and returns the
//    parser to the start of a header, exactly as a restart request does.
//  - The length saturates at 2**LENGTH_BITS - 1 and sets the overflow flag.
`default_nettype none

module sip_stream_message_framer_unit #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  // input: [7:0] in_byte
  input  wire logic [7:0]                               in_tdata,
  // input: [0] cmd
  input  wire logic [0:0]                               in_tuser,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // output: [7:0] out_byte, [LENGTH_BITS+7:8] body_length, zero pad above
  output logic [((8 + LENGTH_BITS + 7) / 8) * 8 - 1:0]  out_tdata,
  // output: [0] in_body, [1] length_overflow
  output logic [1:0]                                    out_tuser,
  output logic                                          out_tlast,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready
);
  import ssmf_pkg::*;

  localparam int TDATA_W = ((8 + LENGTH_BITS + 7) / 8) * 8;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Parser state
  phase_t                 phase_r, phase_nxt;
  nphase_t                nphase_r, nphase_nxt;
  logic [4:0]             mpos_r, mpos_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [LENGTH_BITS-1:0] bcnt_r, bcnt_nxt;

  // Result register
  logic                   out_valid_r;
  logic [7:0]             obyte_r, obyte_nxt;
  logic                   oend_r, oend_nxt;
  logic                   obody_r, obody_nxt;
  logic [LENGTH_BITS-1:0] olen_r, olen_nxt;
  logic                   oovf_r, oovf_nxt;

  logic                   in_acc;
  logic [7:0]             c;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] acc10;
  logic                   sat;
  logic [LENGTH_BITS-1:0] len_add;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign c         = in_tdata;

  // Decimal digit accumulate: len * 10 + digit, saturated
  assign digit   = 4'(c - CH_ZERO);
  assign acc10   = {1'b0, len_r, 3'b000} + {3'b000, len_r, 1'b0} + (LENGTH_BITS + 4)'(digit);
  assign sat     = acc10 > (LENGTH_BITS + 4)'(LEN_MAX);
  assign len_add = sat ? LEN_MAX : acc10[LENGTH_BITS-1:0];

  // Per-byte parse step
  always_comb begin
    phase_nxt  = phase_r;
    nphase_nxt = nphase_r;
    mpos_nxt   = mpos_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    bcnt_nxt   = bcnt_r;
    obyte_nxt  = c;
    oend_nxt   = 1'b0;
    obody_nxt  = 1'b0;
    olen_nxt   = len_r;
    oovf_nxt   = ovf_r;

    if (in_acc && in_tuser[0] == CMD_RESTART) begin
      phase_nxt  = PH_HDR;
      nphase_nxt = NP_MATCH;
      mpos_nxt   = '0;
      len_nxt    = '0;
      ovf_nxt    = 1'b0;
      bcnt_nxt   = '0;
    end else if (in_acc) begin
      if (phase_r == PH_BODY) begin
        // body byte count
        obody_nxt = 1'b1;
        bcnt_nxt  = bcnt_r + 1'b1;
        oend_nxt  = (bcnt_nxt == len_r);
      end else begin
        // header scan
        unique case (nphase_r)
          NP_MATCH: begin
            if (mpos_r < PATTERN_LEN && lower_char(c) == pattern_char(mpos_r)) begin
              mpos_nxt = 5'(mpos_r + 5'd1);
            end else begin
              mpos_nxt = (c == CH_LF) ? 5'd1 : 5'd0;
            end
            if (mpos_nxt >= PATTERN_LEN) begin
              nphase_nxt = NP_BLANK;
            end
          end
          NP_BLANK: begin
            if (c == CH_SPACE || c == CH_TAB) begin
              nphase_nxt = NP_BLANK;
            end else if (is_digit(c)) begin
              nphase_nxt = NP_DIGIT;
              len_nxt    = len_add;
              ovf_nxt    = ovf_r | sat;
            end else begin
              nphase_nxt = NP_DONE;
            end
          end
          NP_DIGIT: begin
            if (is_digit(c)) begin
              len_nxt = len_add;
              ovf_nxt = ovf_r | sat;
            end else begin
              nphase_nxt = NP_DONE;
            end
          end
          NP_DONE: nphase_nxt = NP_DONE;
          default: nphase_nxt = nphase_r;
        endcase

        // blank-line detection
        if (phase_r == PH_NL) begin
          if (c == CH_LF) begin
            if (len_nxt == '0) begin
              oend_nxt = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
              bcnt_nxt  = '0;
            end
          end else if (c != CH_CR) begin
            phase_nxt = PH_HDR;
          end
        end else begin
          phase_nxt = (c == CH_LF) ? PH_NL : PH_HDR;
        end
      end

      olen_nxt = len_nxt;
      oovf_nxt = ovf_nxt;

      // message done: back to the start of a header
      if (oend_nxt) begin
        phase_nxt  = PH_HDR;
        nphase_nxt = NP_MATCH;
        mpos_nxt   = '0;
        len_nxt    = '0;
        ovf_nxt    = 1'b0;
        bcnt_nxt   = '0;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      nphase_r <= NP_MATCH;
      mpos_r   <= '0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      bcnt_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      nphase_r <= nphase_nxt;
      mpos_r   <= mpos_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      bcnt_r   <= bcnt_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && (in_tuser[0] == CMD_DATA);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser[0] == CMD_DATA) begin
      obyte_r <= obyte_nxt;
      oend_r  <= oend_nxt;
      obody_r <= obody_nxt;
      olen_r  <= olen_nxt;
      oovf_r  <= oovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({olen_r, obyte_r});
  assign out_tuser  = {oovf_r, obody_r};
  assign out_tlast  = oend_r;

`ifndef SYNTH
  // restart request clears the length and body count
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == CMD_RESTART) |=> (len_r == '0 && bcnt_r == '0 && !ovf_r))
    else $error("restart did not clear parser state");

  // overflow flag only with a saturated length
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LEN_MAX))
    else $error("overflow flag without saturated length");

  // body phase needs a nonzero length not yet reached
  a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (len_r != '0 && bcnt_r < len_r))
    else $error("body count out of range");

  // a message end returns the parser to a fresh header
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == CMD_DATA && oend_nxt) |=>
      (phase_r == PH_HDR && nphase_r == NP_MATCH && mpos_r == '0))
    else $error("parser not reset after message end");
`endif

endmodule

`default_nettype wire
